// ===== hw/rtl/gbr_pkg.sv =====
package gbr_pkg;

   localparam int BLUR_RADIUS = 2;
   localparam int WEIGHT_BITS = 16;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 1024;

   localparam int RAD_SEL   = (BLUR_RADIUS < 1) ? 0 : ((BLUR_RADIUS > 4) ? 3 : BLUR_RADIUS - 1);
   localparam int REACH     = (257 * (RAD_SEL + 1) + 99) / 100;
   localparam int TAPS      = 2 * REACH + 1;
   localparam int RING_ROWS = 2 * REACH + 2;
   localparam int TAB_LEN   = 12;
   localparam int DY_BITS   = $clog2(REACH + 1);
   localparam int WT_BITS   = WEIGHT_BITS + 1;
   localparam int ACC_BITS  = WEIGHT_BITS + 9;
   localparam int CFG_BITS  = 11;
   localparam int PIX_BITS  = 24;

   localparam logic [CFG_BITS-1:0] WIDTH_RESET  = 11'd640;
   localparam logic [CFG_BITS-1:0] HEIGHT_RESET = 11'd480;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic KIND_PIXEL = 1'b0;
   localparam logic KIND_DRAIN = 1'b1;

   localparam logic [24:0] GAUSS_Q24 [4][TAB_LEN] = '{
      '{25'd16777216, 25'd10175897, 25'd2270550, 25'd186378, 25'd0, 25'd0,
        25'd0, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0},
      '{25'd16777216, 25'd14805841, 25'd10175897, 25'd5446765, 25'd2270550,
        25'd737139, 25'd186378, 25'd0, 25'd0, 25'd0, 25'd0, 25'd0},
      '{25'd16777216, 25'd15870567, 25'd13434144, 25'd10175897, 25'd6897320,
        25'd4183436, 25'd2270550, 25'd1102750, 25'd479241, 25'd0, 25'd0, 25'd0},
      '{25'd16777216, 25'd16261035, 25'd14805841, 25'd12664107, 25'd10175897,
        25'd7681169, 25'd5446765, 25'd3628327, 25'd2270550, 25'd1334789,
        25'd737139, 25'd382420}
   };

   typedef logic [2:0][ACC_BITS-1:0] rgb_sum_type;
   typedef logic [REACH:0][REACH:0][WT_BITS-1:0] weight_table_type;

   function automatic logic [63:0] raw_weight(int a, int b);
      logic [63:0] prod;
      prod = 64'(GAUSS_Q24[RAD_SEL][a]) * 64'(GAUSS_Q24[RAD_SEL][b]);
      return prod >> 24;
   endfunction

   function automatic logic [63:0] raw_total();
      logic [63:0] sum;
      logic [63:0] mult;
      sum = 64'd0;
      for (int a = 0; a <= REACH; a++) begin
         for (int b = 0; b <= REACH; b++) begin
            mult = ((a != 0) ? 64'd2 : 64'd1) * ((b != 0) ? 64'd2 : 64'd1);
            sum = sum + raw_weight(a, b) * mult;
         end
      end
      return sum;
   endfunction

   localparam logic [63:0] RawTotal = raw_total();

   function automatic weight_table_type build_weights();
      weight_table_type tab;
      logic [63:0] given;
      logic [63:0] wq;
      logic [63:0] mult;
      tab = '0;
      given = 64'd0;
      for (int a = 0; a <= REACH; a++) begin
         for (int b = 0; b <= REACH; b++) begin
            wq = (raw_weight(a, b) << WEIGHT_BITS) / RawTotal;
            mult = ((a != 0) ? 64'd2 : 64'd1) * ((b != 0) ? 64'd2 : 64'd1);
            tab[a][b] = WT_BITS'(wq);
            given = given + wq * mult;
         end
      end
      tab[0][0] = tab[0][0] + WT_BITS'((64'd1 << WEIGHT_BITS) - given);
      return tab;
   endfunction

   localparam weight_table_type WEIGHTS = build_weights();

endpackage

// ===== hw/rtl/gaussian_blur_rgb.sv =====
// channel | dir | handshake          | word
// req     | in  | req_tvalid/tready  | tdata: red, green, blue; tuser: kind
// rsp     | out | rsp_tvalid/tready  | tdata: red, green, blue; tlast: last of frame
// csr     | in  | csr_write_enable   | csr_index, csr_wdata
// a word without a result passes through accept, position product and decide
// a word with a result adds taps*taps window reads, one per cycle from the line
// store read port, then the address and tap chain stages and the emit step
// reset is synchronous; it restores the size registers and clears all positions
// a waiting result holds only the final emit step; req stays low until it leaves
module gaussian_blur_rgb #(
   parameter int MAX_WIDTH  = gbr_pkg::MAX_WIDTH,
   parameter int MAX_HEIGHT = gbr_pkg::MAX_HEIGHT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,   // pixel_red, pixel_green, pixel_blue
   input  logic                          req_tuser,   // kind
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,   // out_red, out_green, out_blue
   output logic                          rsp_tlast,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [gbr_pkg::CFG_BITS-1:0]  csr_wdata
);

   localparam int REACH     = gbr_pkg::REACH;
   localparam int TAPS      = gbr_pkg::TAPS;
   localparam int RING_ROWS = gbr_pkg::RING_ROWS;
   localparam int DY_BITS   = gbr_pkg::DY_BITS;
   localparam int ACC_BITS  = gbr_pkg::ACC_BITS;
   localparam int WB        = gbr_pkg::WEIGHT_BITS;
   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
   localparam int EW_BITS   = $clog2(MAX_WIDTH + 1);
   localparam int EH_BITS   = $clog2(MAX_HEIGHT + 1);
   localparam int RING_BITS = $clog2(RING_ROWS);
   localparam int DEPTH     = RING_ROWS * MAX_WIDTH;
   localparam int ADDR_BITS = $clog2(DEPTH);
   localparam int TAP_BITS  = $clog2(TAPS);
   localparam int CNT_BITS  = $clog2(MAX_WIDTH + MAX_HEIGHT + TAPS + gbr_pkg::CFG_BITS) + 2;
   localparam int LIN_BITS  = ROW_BITS + EW_BITS + 1;
   localparam int MOD_SHIFT = ROW_BITS + 8;
   localparam int MOD_RECIP = (1 << MOD_SHIFT) / RING_ROWS;
   localparam int MOD_PBITS = ROW_BITS + MOD_SHIFT;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MEASURE = 3'd1;
   localparam logic [2:0] ST_DECIDE  = 3'd2;
   localparam logic [2:0] ST_SWEEP   = 3'd3;
   localparam logic [2:0] ST_FLUSH   = 3'd4;
   localparam logic [2:0] ST_EMIT    = 3'd5;

   typedef struct packed {
      logic               valid;
      logic               row_end;
      logic               win_end;
      logic [DY_BITS-1:0] dy_abs;
   } tap_ctl_type;

   logic [2:0]                   state_ff, state_in;
   logic [gbr_pkg::CFG_BITS-1:0] width_reg_ff, height_reg_ff;
   logic [COL_BITS-1:0]          in_col_ff, in_col_in;
   logic [ROW_BITS-1:0]          in_row_ff, in_row_in;
   logic [RING_BITS-1:0]         in_ring_ff, in_ring_in;
   logic [COL_BITS-1:0]          out_col_ff, out_col_in;
   logic [ROW_BITS-1:0]          out_row_ff, out_row_in;
   logic                         done_ff, done_in;
   logic [TAP_BITS-1:0]          dx_ff, dx_in, dy_ff, dy_in;
   logic [LIN_BITS-1:0]          lin_in_ff, lin_out_ff;

   logic [EW_BITS-1:0]           w_eff;
   logic [EH_BITS-1:0]           h_eff;
   logic                         accept;
   logic                         wr_en;
   logic [ADDR_BITS-1:0]         wr_addr;
   logic [23:0]                  wr_data;

   tap_ctl_type                  a_ctl_ff, a_ctl_in, b_ctl_ff, c_ctl_ff, d_ctl_ff;
   logic [COL_BITS-1:0]          a_x_ff, a_x_in, b_x_ff;
   logic [ROW_BITS-1:0]          a_y_ff, a_y_in, b_y_ff, b_q_ff;
   logic [ADDR_BITS-1:0]         c_addr_ff, c_addr_in;
   logic [23:0]                  d_pix_ff;
   logic                         e_row_end_ff, e_win_end_ff;

   logic [23:0]                  store_mem [DEPTH];

   gbr_pkg::rgb_sum_type         chain_sum  [TAPS];
   gbr_pkg::rgb_sum_type         chain_link [TAPS];
   logic [23:0]                  chain_pix;
   gbr_pkg::rgb_sum_type         acc_ff, sum_ff;

   logic                         rsp_valid_ff;
   logic [23:0]                  rsp_data_ff, rsp_data_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         emit;

   // effective frame size
   always_comb begin
      if (width_reg_ff == '0) begin
         w_eff = EW_BITS'(1);
      end else if (CNT_BITS'(width_reg_ff) > CNT_BITS'(MAX_WIDTH)) begin
         w_eff = EW_BITS'(MAX_WIDTH);
      end else begin
         w_eff = EW_BITS'(width_reg_ff);
      end
      if (height_reg_ff == '0) begin
         h_eff = EH_BITS'(1);
      end else if (CNT_BITS'(height_reg_ff) > CNT_BITS'(MAX_HEIGHT)) begin
         h_eff = EH_BITS'(MAX_HEIGHT);
      end else begin
         h_eff = EH_BITS'(height_reg_ff);
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign emit       = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   assign wr_en   = accept && (req_tuser == gbr_pkg::KIND_PIXEL);
   assign wr_addr = ADDR_BITS'(in_ring_ff) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(in_col_ff);
   assign wr_data = req_tdata;

   // sweep address generation, first stage
   always_comb begin
      logic [CNT_BITS-1:0] vx, vy;
      vx = CNT_BITS'(out_col_ff) + CNT_BITS'(dx_ff);
      vy = CNT_BITS'(out_row_ff) + CNT_BITS'(dy_ff);
      if (vx < CNT_BITS'(REACH)) begin
         vx = '0;
      end else begin
         vx = vx - CNT_BITS'(REACH);
      end
      if (vx >= CNT_BITS'(w_eff)) begin
         vx = CNT_BITS'(w_eff) - CNT_BITS'(1);
      end
      if (vy < CNT_BITS'(REACH)) begin
         vy = '0;
      end else begin
         vy = vy - CNT_BITS'(REACH);
      end
      if (vy >= CNT_BITS'(h_eff)) begin
         vy = CNT_BITS'(h_eff) - CNT_BITS'(1);
      end
      a_x_in = COL_BITS'(vx);
      a_y_in = ROW_BITS'(vy);
      a_ctl_in.valid   = (state_ff == ST_SWEEP);
      a_ctl_in.row_end = (dx_ff == TAP_BITS'(TAPS - 1));
      a_ctl_in.win_end = (dx_ff == TAP_BITS'(TAPS - 1)) && (dy_ff == TAP_BITS'(TAPS - 1));
      if (dy_ff >= TAP_BITS'(REACH)) begin
         a_ctl_in.dy_abs = DY_BITS'(dy_ff - TAP_BITS'(REACH));
      end else begin
         a_ctl_in.dy_abs = DY_BITS'(TAP_BITS'(REACH) - dy_ff);
      end
   end

   // ring row of the clamped window row, third stage
   always_comb begin
      logic [ROW_BITS-1:0] r;
      r = b_y_ff - ROW_BITS'(ROW_BITS'(b_q_ff) * ROW_BITS'(RING_ROWS));
      if (r >= ROW_BITS'(RING_ROWS)) begin
         r = r - ROW_BITS'(RING_ROWS);
      end
      c_addr_in = ADDR_BITS'(RING_BITS'(r)) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(b_x_ff);
   end

   always_ff @(posedge clock) begin
      a_x_ff    <= a_x_in;
      a_y_ff    <= a_y_in;
      b_x_ff    <= a_x_ff;
      b_y_ff    <= a_y_ff;
      b_q_ff    <= ROW_BITS'((MOD_PBITS'(a_y_ff) * MOD_PBITS'(MOD_RECIP)) >> MOD_SHIFT);
      c_addr_ff <= c_addr_in;
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      d_pix_ff <= store_mem[c_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff     <= '0;
         b_ctl_ff     <= '0;
         c_ctl_ff     <= '0;
         d_ctl_ff     <= '0;
         e_row_end_ff <= 1'b0;
         e_win_end_ff <= 1'b0;
      end else begin
         a_ctl_ff     <= a_ctl_in;
         b_ctl_ff     <= a_ctl_ff;
         c_ctl_ff     <= b_ctl_ff;
         d_ctl_ff     <= c_ctl_ff;
         e_row_end_ff <= d_ctl_ff.valid && d_ctl_ff.row_end;
         e_win_end_ff <= d_ctl_ff.valid && d_ctl_ff.win_end;
      end
   end

   // tap chain, one cell per window column
   assign chain_pix = d_ctl_ff.valid ? d_pix_ff : '0;

   for (genvar t = 0; t < TAPS; t++) begin : g_tap
      if (t == 0) begin : g_head
         assign chain_link[t] = '0;
      end else begin : g_body
         assign chain_link[t] = chain_sum[t-1];
      end
      gbr_cell #(
         .TAP(t)
      ) u_cell (
         .clock  (clock),
         .pix_in (chain_pix),
         .dy_abs (d_ctl_ff.dy_abs),
         .sum_in (chain_link[t]),
         .sum_out(chain_sum[t])
      );
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DECIDE) begin
         acc_ff <= '0;
      end else if (e_row_end_ff) begin
         for (int c = 0; c < 3; c++) begin
            if (e_win_end_ff) begin
               acc_ff[c] <= '0;
               sum_ff[c] <= acc_ff[c] + chain_sum[TAPS-1][c];
            end else begin
               acc_ff[c] <= acc_ff[c] + chain_sum[TAPS-1][c];
            end
         end
      end
   end

   // rounding and saturation
   always_comb begin
      logic [ACC_BITS-1:0] rounded;
      for (int c = 0; c < 3; c++) begin
         rounded = (sum_ff[c] + (ACC_BITS'(1) << (WB - 1))) >> WB;
         if (rounded > ACC_BITS'(255)) begin
            rsp_data_in[8*c +: 8] = 8'hff;
         end else begin
            rsp_data_in[8*c +: 8] = rounded[7:0];
         end
      end
   end

   // positions and sequencer
   always_comb begin
      state_in    = state_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_ring_in  = in_ring_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      done_in     = done_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      rsp_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MEASURE;
               if (req_tuser == gbr_pkg::KIND_PIXEL) begin
                  if (done_ff) begin
                     out_col_in = '0;
                     out_row_in = '0;
                     done_in    = 1'b0;
                  end
                  if (CNT_BITS'(in_col_ff) + CNT_BITS'(1) >= CNT_BITS'(w_eff)) begin
                     in_col_in = '0;
                     if (CNT_BITS'(in_row_ff) + CNT_BITS'(1) >= CNT_BITS'(h_eff)) begin
                        in_row_in  = '0;
                        in_ring_in = '0;
                        done_in    = 1'b1;
                     end else begin
                        in_row_in = in_row_ff + ROW_BITS'(1);
                        if (in_ring_ff == RING_BITS'(RING_ROWS - 1)) begin
                           in_ring_in = '0;
                        end else begin
                           in_ring_in = in_ring_ff + RING_BITS'(1);
                        end
                     end
                  end else begin
                     in_col_in = in_col_ff + COL_BITS'(1);
                  end
               end
            end
         end
         ST_MEASURE: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            dx_in = '0;
            dy_in = '0;
            if (done_ff || (lin_in_ff > lin_out_ff)) begin
               state_in = ST_SWEEP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            if (dx_ff == TAP_BITS'(TAPS - 1)) begin
               dx_in = '0;
               if (dy_ff == TAP_BITS'(TAPS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  dy_in = dy_ff + TAP_BITS'(1);
               end
            end else begin
               dx_in = dx_ff + TAP_BITS'(1);
            end
         end
         ST_FLUSH: begin
            if (e_win_end_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit) begin
               state_in = ST_IDLE;
               if (CNT_BITS'(out_col_ff) + CNT_BITS'(1) >= CNT_BITS'(w_eff)) begin
                  out_col_in = '0;
                  if (CNT_BITS'(out_row_ff) + CNT_BITS'(1) >= CNT_BITS'(h_eff)) begin
                     out_row_in  = '0;
                     rsp_last_in = 1'b1;
                     done_in     = 1'b0;
                  end else begin
                     out_row_in = out_row_ff + ROW_BITS'(1);
                  end
               end else begin
                  out_col_in = out_col_ff + COL_BITS'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // linear positions for the readiness test
   always_ff @(posedge clock) begin
      logic [CNT_BITS-1:0] rn, cn;
      rn = CNT_BITS'(out_row_ff) + CNT_BITS'(REACH);
      cn = CNT_BITS'(out_col_ff) + CNT_BITS'(REACH);
      if (rn > CNT_BITS'(h_eff) - CNT_BITS'(1)) begin
         rn = CNT_BITS'(h_eff) - CNT_BITS'(1);
      end
      if (cn > CNT_BITS'(w_eff) - CNT_BITS'(1)) begin
         cn = CNT_BITS'(w_eff) - CNT_BITS'(1);
      end
      lin_in_ff  <= LIN_BITS'(in_row_ff) * LIN_BITS'(w_eff) + LIN_BITS'(in_col_ff);
      lin_out_ff <= LIN_BITS'(rn) * LIN_BITS'(w_eff) + LIN_BITS'(cn);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         width_reg_ff  <= gbr_pkg::WIDTH_RESET;
         height_reg_ff <= gbr_pkg::HEIGHT_RESET;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         in_ring_ff    <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         done_ff       <= 1'b0;
         dx_ff         <= '0;
         dy_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         in_ring_ff <= in_ring_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         done_ff    <= done_in;
         dx_ff      <= dx_in;
         dy_ff      <= dy_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               gbr_pkg::REG_FRAME_WIDTH:  width_reg_ff  <= csr_wdata;
               gbr_pkg::REG_FRAME_HEIGHT: height_reg_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== hw/rtl/gbr_cell.sv =====
module gbr_cell #(
   parameter int TAP = 0
) (
   input  logic                                clock,
   input  logic [gbr_pkg::PIX_BITS-1:0]        pix_in,
   input  logic [gbr_pkg::DY_BITS-1:0]         dy_abs,
   input  gbr_pkg::rgb_sum_type                sum_in,
   output gbr_pkg::rgb_sum_type                sum_out
);

   localparam int DX_ABS = (TAP > gbr_pkg::REACH) ? TAP - gbr_pkg::REACH : gbr_pkg::REACH - TAP;

   logic [gbr_pkg::WT_BITS-1:0] weight;
   gbr_pkg::rgb_sum_type sum_ff;
   gbr_pkg::rgb_sum_type sum_in_next;

   assign weight = gbr_pkg::WEIGHTS[dy_abs][DX_ABS];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         sum_in_next[c] = sum_in[c]
            + gbr_pkg::ACC_BITS'(pix_in[8*c +: 8]) * gbr_pkg::ACC_BITS'(weight);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in_next;
   end

   assign sum_out = sum_ff;

endmodule
